// ===== rtl/core/dti_pkg.sv =====
package dti_pkg;

    localparam int NODE_COUNT    = 256;
    localparam int FEATURE_COUNT = 64;
    localparam int CLASS_MAX     = 8;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int FEAT_W  = $clog2(FEATURE_COUNT);
    localparam int CLASS_W = $clog2(CLASS_MAX);
    localparam int PROB_W  = 17;

    localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;

    typedef enum logic [2:0] {
        OP_WR_NODE  = 3'd0,
        OP_WR_PROB  = 3'd1,
        OP_WR_FEAT  = 3'd2,
        OP_PRED_LBL = 3'd3,
        OP_PRED_PRB = 3'd4,
        OP_WR_LABEL = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_LEAF    = 2'd0,
        KIND_NUMERIC = 2'd1,
        KIND_CATEG   = 2'd2,
        KIND_INVALID = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_ROOT  = 2'd0,
        REG_CLASS = 2'd1,
        REG_STEP  = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NODE_RD,
        ST_NODE_CHK,
        ST_FEAT_CMP,
        ST_ARG_RD,
        ST_ARG_CMP,
        ST_LBL_RD,
        ST_EMIT_LBL,
        ST_PROB_RD,
        ST_EMIT_PROB,
        ST_EMIT_ERR
    } t_state;

    // One node table word
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  feat;
        logic [31:0] split;
        logic [7:0]  left;
        logic [7:0]  right;
    } t_node;

endpackage

// ===== rtl/core/decision_tree_inference_unit.sv =====
// Decision tree inference unit. Input transactions load a binary decision
// tree (node words), per-leaf class probabilities, class labels and the
// feature values of one sample, or start a walk from root_address. A numeric
// node goes left when the feature is greater than its signed Q16.16 split
// value, a categorical node when the feature equals it. At the leaf the unit
// reports the label of the first most probable class (opcode 3) or every
// class probability in turn with tlast on the final one (opcode 4). An
// invalid node, an address or feature outside the tables, or more than
// step_limit visited nodes gives a single result with tuser (status) set.
// Write transactions are taken in the idle state. A predict transaction
// holds the input side until its last result is registered: each level
// on the path costs a node table read, a feature read and a pass through
// the shared comparator, each class in use a probability memory read and
// a compare, and in probability mode a second read per class for its
// result, all on single read ports. The result register lets one result
// wait for the consumer while the next write transaction is taken.
// Configuration (APB, 32-bit data): 0x0 root_address, 0x4 class_count,
// 0x8 step_limit; write only while the unit is idle.
module decision_tree_inference_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: node_address(8) node_kind(2) feature_index(6)
    // split_value(32) left_child(8) right_child(8) class_slot(6)
    // probability_in(17) feature_value(32) label_in(16), zero pad(1)
    input  logic [135:0] s_axis_tdata,
    // tuser from bit 0: opcode(3)
    input  logic [2:0]   s_axis_tuser,
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: predicted_label(16) class_number(6)
    // probability_out(17), zero pad(1)
    output logic [39:0]  m_axis_tdata,
    // tuser from bit 0: status(1)
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    // Configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NW = dti_pkg::NODE_W;
    localparam int FW = dti_pkg::FEAT_W;
    localparam int CW = dti_pkg::CLASS_W;
    localparam int PW = dti_pkg::PROB_W;

    // Input fields
    logic [7:0]         in_addr;
    logic [1:0]         in_kind;
    logic [5:0]         in_feat;
    logic [31:0]        in_split;
    logic [7:0]         in_left;
    logic [7:0]         in_right;
    logic [5:0]         in_slot;
    logic [PW-1:0]      in_prob;
    logic [31:0]        in_fval;
    logic [15:0]        in_label;
    dti_pkg::t_opcode   in_op;

    assign in_addr  = s_axis_tdata[7:0];
    assign in_kind  = s_axis_tdata[9:8];
    assign in_feat  = s_axis_tdata[15:10];
    assign in_split = s_axis_tdata[47:16];
    assign in_left  = s_axis_tdata[55:48];
    assign in_right = s_axis_tdata[63:56];
    assign in_slot  = s_axis_tdata[69:64];
    assign in_prob  = s_axis_tdata[86:70];
    assign in_fval  = s_axis_tdata[118:87];
    assign in_label = s_axis_tdata[134:119];
    assign in_op    = dti_pkg::t_opcode'(s_axis_tuser);

    // Configuration registers
    logic [7:0] r_root;
    logic [6:0] r_ccount;
    logic [7:0] r_slimit;
    logic       cfg_wr;
    dti_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = dti_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root   <= 8'd0;
            r_ccount <= 7'd2;
            r_slimit <= 8'd32;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                dti_pkg::REG_ROOT:  r_root   <= pwdata[7:0];
                dti_pkg::REG_CLASS: r_ccount <= pwdata[6:0];
                dti_pkg::REG_STEP:  r_slimit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            dti_pkg::REG_ROOT:  prdata = {24'd0, r_root};
            dti_pkg::REG_CLASS: prdata = {25'd0, r_ccount};
            dti_pkg::REG_STEP:  prdata = {24'd0, r_slimit};
            default:            prdata = 32'd0;
        endcase
    end

    // Effective class count (1..CLASS_MAX) and step limit (1..255)
    logic [CW:0] n_cls_eff;
    logic [7:0]  limit_eff;

    always_comb begin
        if (r_ccount == 7'd0) begin
            n_cls_eff = (CW+1)'(1);
        end else if (r_ccount > 7'(dti_pkg::CLASS_MAX)) begin
            n_cls_eff = (CW+1)'(dti_pkg::CLASS_MAX);
        end else begin
            n_cls_eff = r_ccount[CW:0];
        end
        limit_eff = (r_slimit == 8'd0) ? 8'd1 : r_slimit;
    end

    // Sequencer registers
    dti_pkg::t_state r_state, n_state;
    logic            r_prob_mode, n_prob_mode;
    logic [7:0]      r_addr, n_addr;
    logic [8:0]      r_visit, n_visit;
    logic [NW-1:0]   r_leaf, n_leaf;
    logic [CW-1:0]   r_cls, n_cls;
    logic [CW-1:0]   r_best, n_best;
    logic [PW-1:0]   r_bestp, n_bestp;

    // Result register
    logic            r_out_valid, n_out_valid;
    logic            r_out_status, n_out_status;
    logic [15:0]     r_out_label, n_out_label;
    logic [5:0]      r_out_class, n_out_class;
    logic [PW-1:0]   r_out_prob, n_out_prob;
    logic            r_out_last, n_out_last;

    // Memories and their registered read data
    dti_pkg::t_node  node_mem [dti_pkg::NODE_COUNT];
    logic [PW-1:0]   prob_mem [dti_pkg::NODE_COUNT * dti_pkg::CLASS_MAX];
    logic [31:0]     feat_mem [dti_pkg::FEATURE_COUNT];
    logic [15:0]     label_mem [dti_pkg::CLASS_MAX];

    dti_pkg::t_node  r_node_q;
    logic [PW-1:0]   r_prob_q;
    logic [31:0]     r_feat_q;
    logic [15:0]     r_lab_q;

    logic node_rd_en, prob_rd_en, feat_rd_en, lab_rd_en;

    // Write decode for accepted transactions
    logic in_acc;
    logic wr_node, wr_prob, wr_feat, wr_label;
    logic [PW-1:0] prob_sat;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign prob_sat = (in_prob > dti_pkg::PROB_ONE) ? dti_pkg::PROB_ONE : in_prob;

    always_comb begin
        wr_node  = 1'b0;
        wr_prob  = 1'b0;
        wr_feat  = 1'b0;
        wr_label = 1'b0;
        unique case (in_op)
            dti_pkg::OP_WR_NODE:
                wr_node = in_acc && ({1'b0, in_addr} < 9'(dti_pkg::NODE_COUNT));
            dti_pkg::OP_WR_PROB:
                wr_prob = in_acc && ({1'b0, in_addr} < 9'(dti_pkg::NODE_COUNT))
                          && ({1'b0, in_slot} < 7'(dti_pkg::CLASS_MAX));
            dti_pkg::OP_WR_FEAT:
                wr_feat = in_acc && ({1'b0, in_feat} < 7'(dti_pkg::FEATURE_COUNT));
            dti_pkg::OP_WR_LABEL:
                wr_label = in_acc && ({1'b0, in_slot} < 7'(dti_pkg::CLASS_MAX));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_node) begin
            node_mem[in_addr[NW-1:0]] <= '{kind: in_kind, feat: in_feat, split: in_split,
                                           left: in_left, right: in_right};
        end
        if (node_rd_en) begin
            r_node_q <= node_mem[r_addr[NW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_prob) begin
            prob_mem[{in_addr[NW-1:0], in_slot[CW-1:0]}] <= prob_sat;
        end
        if (prob_rd_en) begin
            r_prob_q <= prob_mem[{r_leaf, r_cls}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_feat) begin
            feat_mem[in_feat[FW-1:0]] <= in_fval;
        end
        if (feat_rd_en) begin
            r_feat_q <= feat_mem[r_node_q.feat[FW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_label) begin
            label_mem[in_slot[CW-1:0]] <= in_label;
        end
        if (lab_rd_en) begin
            r_lab_q <= label_mem[r_best];
        end
    end

    // Shared comparator: signed features in the walk, zero-extended
    // probabilities in the argmax
    logic signed [32:0] cmp_a, cmp_b;
    logic               cmp_gt, cmp_eq;

    assign cmp_gt = cmp_a > cmp_b;
    assign cmp_eq = cmp_a == cmp_b;

    logic slot_free;
    logic cls_last;
    dti_pkg::t_kind node_kind;

    assign slot_free = !r_out_valid || m_axis_tready;
    assign cls_last  = (({1'b0, r_cls} + (CW+1)'(1)) == n_cls_eff);
    assign node_kind = dti_pkg::t_kind'(r_node_q.kind);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dti_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prob_mode  <= n_prob_mode;
        r_addr       <= n_addr;
        r_visit      <= n_visit;
        r_leaf       <= n_leaf;
        r_cls        <= n_cls;
        r_best       <= n_best;
        r_bestp      <= n_bestp;
        r_out_status <= n_out_status;
        r_out_label  <= n_out_label;
        r_out_class  <= n_out_class;
        r_out_prob   <= n_out_prob;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_prob_mode  = r_prob_mode;
        n_addr       = r_addr;
        n_visit      = r_visit;
        n_leaf       = r_leaf;
        n_cls        = r_cls;
        n_best       = r_best;
        n_bestp      = r_bestp;
        // Drop the held result once the consumer takes it
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_label  = r_out_label;
        n_out_class  = r_out_class;
        n_out_prob   = r_out_prob;
        n_out_last   = r_out_last;
        node_rd_en   = 1'b0;
        prob_rd_en   = 1'b0;
        feat_rd_en   = 1'b0;
        lab_rd_en    = 1'b0;
        cmp_a        = 33'sd0;
        cmp_b        = 33'sd0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            dti_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (in_op == dti_pkg::OP_PRED_LBL ||
                                      in_op == dti_pkg::OP_PRED_PRB)) begin
                    n_prob_mode = (in_op == dti_pkg::OP_PRED_PRB);
                    n_addr      = r_root;
                    n_visit     = 9'd0;
                    n_state     = dti_pkg::ST_NODE_RD;
                end
            end
            dti_pkg::ST_NODE_RD: begin
                n_visit = r_visit + 9'd1;
                if (({1'b0, r_addr} >= 9'(dti_pkg::NODE_COUNT)) ||
                    (n_visit > {1'b0, limit_eff})) begin
                    n_state = dti_pkg::ST_EMIT_ERR;
                end else begin
                    node_rd_en = 1'b1;
                    n_state    = dti_pkg::ST_NODE_CHK;
                end
            end
            dti_pkg::ST_NODE_CHK: begin
                unique case (node_kind)
                    dti_pkg::KIND_LEAF: begin
                        n_leaf  = r_addr[NW-1:0];
                        n_cls   = '0;
                        n_state = dti_pkg::ST_ARG_RD;
                    end
                    dti_pkg::KIND_NUMERIC, dti_pkg::KIND_CATEG: begin
                        if ({1'b0, r_node_q.feat} >= 7'(dti_pkg::FEATURE_COUNT)) begin
                            n_state = dti_pkg::ST_EMIT_ERR;
                        end else begin
                            feat_rd_en = 1'b1;
                            n_state    = dti_pkg::ST_FEAT_CMP;
                        end
                    end
                    default: n_state = dti_pkg::ST_EMIT_ERR;
                endcase
            end
            dti_pkg::ST_FEAT_CMP: begin
                cmp_a = {r_feat_q[31], r_feat_q};
                cmp_b = {r_node_q.split[31], r_node_q.split};
                if ((node_kind == dti_pkg::KIND_NUMERIC) ? cmp_gt : cmp_eq) begin
                    n_addr = r_node_q.left;
                end else begin
                    n_addr = r_node_q.right;
                end
                n_state = dti_pkg::ST_NODE_RD;
            end
            dti_pkg::ST_ARG_RD: begin
                prob_rd_en = 1'b1;
                n_state    = dti_pkg::ST_ARG_CMP;
            end
            dti_pkg::ST_ARG_CMP: begin
                // First maximum wins: update only on strictly greater
                cmp_a = {16'd0, r_prob_q};
                cmp_b = {16'd0, r_bestp};
                if (r_cls == '0 || cmp_gt) begin
                    n_best  = r_cls;
                    n_bestp = r_prob_q;
                end
                if (cls_last) begin
                    n_state = dti_pkg::ST_LBL_RD;
                end else begin
                    n_cls   = r_cls + CW'(1);
                    n_state = dti_pkg::ST_ARG_RD;
                end
            end
            dti_pkg::ST_LBL_RD: begin
                lab_rd_en = 1'b1;
                if (r_prob_mode) begin
                    n_cls   = '0;
                    n_state = dti_pkg::ST_PROB_RD;
                end else begin
                    n_state = dti_pkg::ST_EMIT_LBL;
                end
            end
            dti_pkg::ST_EMIT_LBL: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = 1'b0;
                    n_out_label  = r_lab_q;
                    n_out_class  = 6'(r_best);
                    n_out_prob   = r_bestp;
                    n_out_last   = 1'b1;
                    n_state      = dti_pkg::ST_IDLE;
                end
            end
            dti_pkg::ST_PROB_RD: begin
                prob_rd_en = 1'b1;
                n_state    = dti_pkg::ST_EMIT_PROB;
            end
            dti_pkg::ST_EMIT_PROB: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = 1'b0;
                    n_out_label  = r_lab_q;
                    n_out_class  = 6'(r_cls);
                    n_out_prob   = r_prob_q;
                    n_out_last   = cls_last;
                    if (cls_last) begin
                        n_state = dti_pkg::ST_IDLE;
                    end else begin
                        n_cls   = r_cls + CW'(1);
                        n_state = dti_pkg::ST_PROB_RD;
                    end
                end
            end
            dti_pkg::ST_EMIT_ERR: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = 1'b1;
                    n_out_label  = 16'd0;
                    n_out_class  = 6'd0;
                    n_out_prob   = '0;
                    n_out_last   = 1'b1;
                    n_state      = dti_pkg::ST_IDLE;
                end
            end
            default: n_state = dti_pkg::ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_prob, r_out_class, r_out_label};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== bench/tree_walk_checker.sv =====
`timescale 1ns / 100ps

module tree_walk_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    // from bit 0: node_address(8) node_kind(2) feature_index(6) split_value(32)
    // left_child(8) right_child(8) class_slot(6) probability_in(17)
    // feature_value(32) label_in(16), zero pad(1)
    input  logic [135:0] i_in_data,
    // from bit 0: opcode(3)
    input  logic [2:0]   i_in_op,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    // from bit 0: predicted_label(16) class_number(6) probability_out(17), zero pad(1)
    input  logic [39:0]  i_res_data,
    // from bit 0: status(1)
    input  logic [0:0]   i_res_status,
    input  logic         i_res_last,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic         i_pready,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output int           o_fail_count,
    output int           o_outstanding
);

    typedef struct packed {
        logic        pad;
        logic [15:0] label_in;
        logic [31:0] feature_value;
        logic [16:0] probability_in;
        logic [5:0]  class_slot;
        logic [7:0]  right_child;
        logic [7:0]  left_child;
        logic [31:0] split_value;
        logic [5:0]  feature_index;
        logic [1:0]  node_kind;
        logic [7:0]  node_address;
    } t_item_word;

    typedef struct packed {
        logic        pad;
        logic [16:0] prob;
        logic [5:0]  cls;
        logic [15:0] label;
    } t_result_word;

    typedef struct {
        logic        status;
        logic [15:0] label;
        logic [5:0]  cls;
        logic [16:0] prob;
        logic        last;
    } t_expected;

    dti_pkg::t_node node_tab  [dti_pkg::NODE_COUNT];
    logic [16:0]    leaf_prob [dti_pkg::NODE_COUNT][dti_pkg::CLASS_MAX];
    logic [31:0]    feat_tab  [dti_pkg::FEATURE_COUNT];
    logic [15:0]    label_tab [dti_pkg::CLASS_MAX];

    logic [7:0]  root_addr;
    logic [6:0]  class_count;
    logic [7:0]  step_limit;

    t_expected   results_due [$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t ns: %s differs, expected %0h, got %0h", $time, what, want, got);
        o_fail_count++;
    endtask

    task automatic queue_result(input logic st, input logic [15:0] lab,
                                input logic [5:0] cls, input logic [16:0] prob,
                                input logic last);
        t_expected e;
        e.status = st;
        e.label  = lab;
        e.cls    = cls;
        e.prob   = prob;
        e.last   = last;
        results_due.insert(results_due.size(), e);
    endtask

    // Follow the tree from the root; 0 on a bad node or a step overrun.
    function automatic bit trace_path(output int unsigned leaf);
        int unsigned    addr;
        int unsigned    limit;
        dti_pkg::t_node nd;
        logic           go_left;
        addr  = root_addr;
        limit = (step_limit == 0) ? 1 : step_limit;
        leaf  = 0;
        for (int unsigned visited = 1; visited <= limit; visited++) begin
            if (addr >= dti_pkg::NODE_COUNT)
                return 1'b0;
            nd = node_tab[addr];
            if (nd.kind == dti_pkg::KIND_LEAF) begin
                leaf = addr;
                return 1'b1;
            end
            if (nd.kind != dti_pkg::KIND_NUMERIC && nd.kind != dti_pkg::KIND_CATEG)
                return 1'b0;
            if (nd.feat >= dti_pkg::FEATURE_COUNT)
                return 1'b0;
            if (nd.kind == dti_pkg::KIND_NUMERIC)
                go_left = $signed(feat_tab[nd.feat]) > $signed(nd.split);
            else
                go_left = feat_tab[nd.feat] == nd.split;
            addr = go_left ? nd.left : nd.right;
        end
        return 1'b0;
    endfunction

    task automatic predict_walk(input logic [2:0] op);
        int unsigned leaf;
        int unsigned n;
        int unsigned best;
        logic [16:0] bestp;
        logic [15:0] lab;
        if (!trace_path(leaf)) begin
            queue_result(1'b1, '0, '0, '0, 1'b1);
            return;
        end
        n = class_count;
        if (n == 0)
            n = 1;
        if (n > dti_pkg::CLASS_MAX)
            n = dti_pkg::CLASS_MAX;
        best  = 0;
        bestp = leaf_prob[leaf][0];
        for (int unsigned c = 1; c < n; c++) begin
            if (leaf_prob[leaf][c] > bestp) begin
                bestp = leaf_prob[leaf][c];
                best  = c;
            end
        end
        lab = label_tab[best];
        if (op == dti_pkg::OP_PRED_LBL) begin
            queue_result(1'b0, lab, best[5:0], bestp, 1'b1);
        end else begin
            for (int unsigned c = 0; c < n; c++)
                queue_result(1'b0, lab, c[5:0], leaf_prob[leaf][c], c + 1 == n);
        end
    endtask

    task automatic absorb_item(input logic [2:0] op, input t_item_word w);
        logic [16:0] p;
        case (op)
            dti_pkg::OP_WR_NODE: begin
                node_tab[w.node_address] = {w.node_kind, w.feature_index, w.split_value,
                                            w.left_child, w.right_child};
            end
            dti_pkg::OP_WR_PROB: begin
                p = (w.probability_in > dti_pkg::PROB_ONE) ? dti_pkg::PROB_ONE
                                                           : w.probability_in;
                if (w.class_slot < dti_pkg::CLASS_MAX)
                    leaf_prob[w.node_address][w.class_slot] = p;
            end
            dti_pkg::OP_WR_FEAT: begin
                if (w.feature_index < dti_pkg::FEATURE_COUNT)
                    feat_tab[w.feature_index] = w.feature_value;
            end
            dti_pkg::OP_WR_LABEL: begin
                if (w.class_slot < dti_pkg::CLASS_MAX)
                    label_tab[w.class_slot] = w.label_in;
            end
            dti_pkg::OP_PRED_LBL, dti_pkg::OP_PRED_PRB: predict_walk(op);
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result_word got;
        t_expected    want;
        if (!i_rst_n) begin
            root_addr   = 8'd0;
            class_count = 7'd2;
            step_limit  = 8'd32;
            results_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    dti_pkg::REG_ROOT:  root_addr   = i_pwdata[7:0];
                    dti_pkg::REG_CLASS: class_count = i_pwdata[6:0];
                    dti_pkg::REG_STEP:  step_limit  = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (results_due.size() == 0) begin
                    flag_mismatch("unexpected result", '0, 32'({got.label, i_res_status}));
                end else begin
                    want = results_due.pop_front();
                    if (i_res_status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(i_res_status));
                    if (got.label !== want.label)
                        flag_mismatch("predicted_label", 32'(want.label), 32'(got.label));
                    if (got.cls !== want.cls)
                        flag_mismatch("class_number", 32'(want.cls), 32'(got.cls));
                    if (got.prob !== want.prob)
                        flag_mismatch("probability_out", 32'(want.prob), 32'(got.prob));
                    if (i_res_last !== want.last)
                        flag_mismatch("last_result", 32'(want.last), 32'(i_res_last));
                end
            end
            if (i_in_valid && i_in_ready)
                absorb_item(i_in_op, i_in_data);
        end
        o_outstanding <= results_due.size();
    end

endmodule

// ===== bench/decision_tree_inference_unit_tb.sv =====
`timescale 1ns / 100ps

module decision_tree_inference_unit_tb;

    // Same layout as the input tdata, lowest field at the bottom.
    typedef struct packed {
        logic        pad;
        logic [15:0] label_in;
        logic [31:0] feature_value;
        logic [16:0] probability_in;
        logic [5:0]  class_slot;
        logic [7:0]  right_child;
        logic [7:0]  left_child;
        logic [31:0] split_value;
        logic [5:0]  feature_index;
        logic [1:0]  node_kind;
        logic [7:0]  node_address;
    } t_item_word;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // from bit 0: node_address(8) node_kind(2) feature_index(6) split_value(32)
    // left_child(8) right_child(8) class_slot(6) probability_in(17)
    // feature_value(32) label_in(16), zero pad(1)
    logic [135:0] s_axis_tdata  = '0;
    // from bit 0: opcode(3)
    logic [2:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b1;
    // from bit 0: predicted_label(16) class_number(6) probability_out(17), zero pad(1)
    logic [39:0]  m_axis_tdata;
    // from bit 0: status(1)
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [3:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int outstanding;

    // Stimulus bookkeeping: which entries hold data, so that no walk ever
    // touches a node, feature, probability or label that was never written.
    // A node is live once written; every live split points at live nodes
    // (or itself) and tests a written feature; every live leaf has all
    // CLASS_MAX probabilities written, whatever class_count is later.
    bit          node_live [dti_pkg::NODE_COUNT];
    logic [7:0]  prob_mask [dti_pkg::NODE_COUNT];
    bit          feat_known [dti_pkg::FEATURE_COUNT];
    logic [31:0] feat_val [dti_pkg::FEATURE_COUNT];
    int          nodes_live [$];
    int          feats_written [$];
    logic [7:0]  addr_pool [16];

    int items_sent = 0;
    bit src_quiet  = 1'b0;
    bit sink_quiet = 1'b0;
    int stall_left = 0;

    decision_tree_inference_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tree_walk_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_op       (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_status  (m_axis_tuser),
        .i_res_last    (m_axis_tlast),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run (every walk at the full
    // step limit, every result held by a long consumer stall).
    initial begin
        #200_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side back-pressure: mostly short stalls, now and then a long
    // one, none at all while sink_quiet is set.
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n || sink_quiet) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 20)
                stall_left <= $urandom_range(1, 3);
            else if (r < 24)
                stall_left <= $urandom_range(4, 15);
            else if (r == 24)
                stall_left <= $urandom_range(30, 80);
        end
    end

    function automatic int pick_gap();
        int r;
        if (src_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random filler for the fields an opcode does not use; keep the pad low.
    function automatic t_item_word rand_word();
        logic [159:0] bits;
        t_item_word   w;
        bits  = {$urandom, $urandom, $urandom, $urandom, $urandom};
        w     = bits[135:0];
        w.pad = 1'b0;
        return w;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Probabilities: exact one, zero, oversize (saturates), and a small set
    // of repeats so that ties for the maximum turn up often.
    function automatic logic [16:0] pick_prob();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return dti_pkg::PROB_ONE;
            2: return 17'($urandom_range(65537, 131071));
            3, 4, 5: return 17'(16384 * $urandom_range(1, 3));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Split values near the feature currently held, so both branches occur.
    function automatic logic [31:0] pick_split(input dti_pkg::t_kind kind,
                                               input logic [31:0] fv);
        if (kind == dti_pkg::KIND_CATEG)
            return ($urandom_range(0, 1) == 0) ? fv : pick_value();
        case ($urandom_range(0, 4))
            0: return fv;
            1: return fv - 32'd1;
            2: return fv + 32'd1;
            default: return pick_value();
        endcase
    endfunction

    function automatic logic [7:0] pick_child(input logic [7:0] self_addr);
        if ($urandom_range(0, 99) < 15)
            return self_addr;
        return 8'(nodes_live[$urandom_range(0, nodes_live.size() - 1)]);
    endfunction

    // Present one transaction and hold it until taken. Lower tvalid only
    // when a gap follows, so it never drops and rises in one time step.
    task automatic push_item(input logic [2:0] op, input t_item_word w, input bit counted);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (counted)
            items_sent++;
    endtask

    task automatic send_feature(input logic [5:0] idx, input logic [31:0] val);
        t_item_word w;
        w               = rand_word();
        w.feature_index = idx;
        w.feature_value = val;
        push_item(dti_pkg::OP_WR_FEAT, w, 1'b1);
        feat_val[idx] = val;
        if (!feat_known[idx]) begin
            feat_known[idx] = 1'b1;
            feats_written.insert(feats_written.size(), int'(idx));
        end
    endtask

    task automatic send_label(input logic [5:0] slot, input logic [15:0] val);
        t_item_word w;
        w            = rand_word();
        w.class_slot = slot;
        w.label_in   = val;
        push_item(dti_pkg::OP_WR_LABEL, w, slot < dti_pkg::CLASS_MAX);
    endtask

    task automatic send_prob(input logic [7:0] addr, input logic [5:0] slot,
                             input logic [16:0] p);
        t_item_word w;
        w                = rand_word();
        w.node_address   = addr;
        w.class_slot     = slot;
        w.probability_in = p;
        push_item(dti_pkg::OP_WR_PROB, w, slot < dti_pkg::CLASS_MAX);
        if (slot < dti_pkg::CLASS_MAX)
            prob_mask[addr][slot] = 1'b1;
    endtask

    task automatic send_node(input logic [7:0] addr, input dti_pkg::t_kind kind,
                             input logic [5:0] f, input logic [31:0] sv,
                             input logic [7:0] lc, input logic [7:0] rc);
        t_item_word w;
        w               = rand_word();
        w.node_address  = addr;
        w.node_kind     = kind;
        w.feature_index = f;
        w.split_value   = sv;
        w.left_child    = lc;
        w.right_child   = rc;
        push_item(dti_pkg::OP_WR_NODE, w, 1'b1);
        if (!node_live[addr]) begin
            node_live[addr] = 1'b1;
            nodes_live.insert(nodes_live.size(), int'(addr));
        end
    endtask

    // Complete the probability row of a leaf before anything can walk to it.
    task automatic fill_leaf(input logic [7:0] addr);
        for (int s = 0; s < dti_pkg::CLASS_MAX; s++)
            if (!prob_mask[addr][s])
                send_prob(addr, 6'(s), pick_prob());
    endtask

    task automatic make_node(input logic [7:0] addr, input dti_pkg::t_kind kind);
        logic [5:0]  f;
        logic [31:0] sv;
        logic [7:0]  lc;
        logic [7:0]  rc;
        if (kind == dti_pkg::KIND_NUMERIC || kind == dti_pkg::KIND_CATEG) begin
            if (feats_written.size() == 0 || $urandom_range(0, 5) == 0)
                send_feature(6'($urandom_range(0, dti_pkg::FEATURE_COUNT - 1)),
                             pick_value());
            f  = 6'(feats_written[$urandom_range(0, feats_written.size() - 1)]);
            sv = pick_split(kind, feat_val[f]);
            lc = pick_child(addr);
            rc = pick_child(addr);
        end else begin
            f  = 6'($urandom);
            sv = $urandom;
            lc = 8'($urandom);
            rc = 8'($urandom);
        end
        send_node(addr, kind, f, sv, lc, rc);
        if (kind == dti_pkg::KIND_LEAF)
            fill_leaf(addr);
    endtask

    task automatic send_predict(input logic [2:0] op);
        push_item(op, rand_word(), 1'b1);
    endtask

    // Drop tvalid, wait for every queued result, then let the unit go quiet.
    task automatic settle(input int extra);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Setup then access phase, then an idle spell with psel low, so psel never falls
    // and rises in the same step between back-to-back writes.
    task automatic apb_write(input dti_pkg::t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only with the unit idle: drained, then a margin for
    // write transactions that give no result.
    task automatic configure(input logic [7:0] root, input logic [6:0] classes,
                             input logic [7:0] steps);
        settle(12);
        apb_write(dti_pkg::REG_ROOT, {24'd0, root});
        apb_write(dti_pkg::REG_CLASS, {25'd0, classes});
        apb_write(dti_pkg::REG_STEP, {24'd0, steps});
    endtask

    task automatic random_action();
        int             r;
        dti_pkg::t_kind kind;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                kind = dti_pkg::KIND_LEAF;
            else if (r < 65)
                kind = dti_pkg::KIND_NUMERIC;
            else if (r < 90)
                kind = dti_pkg::KIND_CATEG;
            else
                kind = dti_pkg::KIND_INVALID;
            make_node(addr_pool[$urandom_range(0, 15)], kind);
        end else if (r < 40) begin
            send_prob(($urandom_range(0, 3) == 0) ? 8'($urandom) : addr_pool[$urandom_range(0, 15)],
                      ($urandom_range(0, 9) == 0)
                          ? 6'($urandom_range(8, 63))
                          : 6'($urandom_range(0, dti_pkg::CLASS_MAX - 1)),
                      pick_prob());
        end else if (r < 50) begin
            send_feature(6'($urandom_range(0, dti_pkg::FEATURE_COUNT - 1)), pick_value());
        end else if (r < 55) begin
            send_label(($urandom_range(0, 4) == 0)
                           ? 6'($urandom_range(8, 63))
                           : 6'($urandom_range(0, dti_pkg::CLASS_MAX - 1)),
                       16'($urandom));
        end else if (r < 97) begin
            send_predict(($urandom_range(0, 1) == 0) ? dti_pkg::OP_PRED_LBL
                                                     : dti_pkg::OP_PRED_PRB);
        end else begin
            // unused opcodes: no effect, no result
            push_item(3'($urandom_range(6, 7)), rand_word(), 1'b0);
        end
    endtask

    initial begin
        logic [6:0] class_plan [6];
        logic [7:0] step_plan [6];
        logic [7:0] root;
        int         target;
        class_plan = '{7'd8, 7'd64, 7'd1, 7'd0, 7'd127, 7'd3};
        step_plan  = '{8'd255, 8'd1, 8'd0, 8'd6, 8'd32, 8'd200};

        addr_pool[0] = 8'h00;
        addr_pool[1] = 8'hFF;
        addr_pool[2] = 8'hAA;
        addr_pool[3] = 8'h55;
        for (int i = 4; i < 16; i++)
            addr_pool[i] = 8'($urandom_range(1, 254));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Labels first, extremes of the 16-bit range included;
        // slot 63 lies beyond the label store and is dropped.
        send_label(6'd0, 16'h8000);
        send_label(6'd1, 16'h7FFF);
        send_label(6'd2, 16'h0000);
        send_label(6'd3, 16'hFFFF);
        send_label(6'd4, 16'h0001);
        send_label(6'd5, 16'h5555);
        send_label(6'd6, 16'hAAAA);
        send_label(6'd7, 16'h1234);
        send_label(6'd63, 16'h0F0F);
        send_feature(6'd0, 32'h7FFF_FFFF);
        send_feature(6'(dti_pkg::FEATURE_COUNT - 1), 32'h8000_0000);

        // Leaf at 0: slot 0 at exactly one, slot 1 oversize so it saturates
        // to a tie, slot 6 oversize too; the first maximum must win.
        send_node(8'h00, dti_pkg::KIND_LEAF, 6'h3F, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_prob(8'h00, 6'd0, dti_pkg::PROB_ONE);
        send_prob(8'h00, 6'd1, 17'h1FFFF);
        send_prob(8'h00, 6'd2, 17'd0);
        send_prob(8'h00, 6'd3, 17'd1);
        send_prob(8'h00, 6'd4, 17'd65535);
        send_prob(8'h00, 6'd5, 17'd32768);
        send_prob(8'h00, 6'd6, 17'h10001);
        send_prob(8'h00, 6'd7, 17'd12345);
        send_prob(8'h00, 6'd8, 17'd100);
        push_item(3'd6, rand_word(), 1'b0);
        push_item(3'd7, rand_word(), 1'b0);
        send_predict(dti_pkg::OP_PRED_LBL);
        send_predict(dti_pkg::OP_PRED_PRB);

        // Numeric split at the top address, categorical split on the top
        // feature, and an invalid node.
        send_node(8'hFF, dti_pkg::KIND_NUMERIC, 6'd0, 32'h7FFF_FFFE, 8'h00, 8'h00);
        send_node(8'hAA, dti_pkg::KIND_CATEG, 6'd63, 32'h8000_0000, 8'hFF, 8'h00);
        send_node(8'h55, dti_pkg::KIND_INVALID, 6'h2A, 32'h1234_5678, 8'h00, 8'hFF);

        // Two-level walk with class_count beyond the maximum (saturates).
        configure(8'hAA, 7'd127, 8'd255);
        send_predict(dti_pkg::OP_PRED_LBL);
        send_predict(dti_pkg::OP_PRED_PRB);
        // Invalid node at the root; class_count and step_limit zero.
        configure(8'h55, 7'd0, 8'd0);
        send_predict(dti_pkg::OP_PRED_LBL);
        // Three nodes on the path against a limit of two: step overrun.
        configure(8'hAA, 7'd1, 8'd2);
        send_predict(dti_pkg::OP_PRED_PRB);

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0)
                root = 8'hFF;
            else if (phase == 1)
                root = 8'h00;
            else
                root = 8'(nodes_live[$urandom_range(0, nodes_live.size() - 1)]);
            configure(root, class_plan[phase], step_plan[phase]);
            src_quiet  = (phase == 2);
            sink_quiet <= (phase == 4);
            target     = items_sent + 65;
            while (items_sent < target) begin
                random_action();
                // hold off once mid-run until every result has come back
                if (phase == 1 && items_sent == target - 30)
                    settle(0);
            end
        end

        settle(40);
        if (fail_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== decision_tree_inference_unit.f =====
rtl/core/dti_pkg.sv
rtl/core/decision_tree_inference_unit.sv
bench/tree_walk_checker.sv
bench/decision_tree_inference_unit_tb.sv
